// ===== rtl/core/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants and types of the text console character writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned RADDR_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned S_DATA_W  = 24;
  localparam int unsigned M_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_CELL = 2'd1;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0000;

  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic clearing;
    logic idle;
  } tcw_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcw_cell_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_mem
// screen cell store, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_cell_mem #(
  parameter int unsigned DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/tcw_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_engine
// cursor keeping and cell sequencer: clear, put, tab, line feed, scroll, read
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS,
  parameter int unsigned ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   attr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0]   blank_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         in_op_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   in_char_i,
  input  wire logic                         in_adv_i,
  input  wire logic [tcw_pkg::RADDR_W-1:0]  in_addr_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output logic      [tcw_pkg::POS_W-1:0]    res_pos_o,
  output logic      [tcw_pkg::CELL_W-1:0]   res_data_o,
  output logic                              mem_we_o,
  output logic      [ADDR_W-1:0]            mem_waddr_o,
  output logic      [tcw_pkg::CELL_W-1:0]   mem_wdata_o,
  output logic                              mem_re_o,
  output logic      [ADDR_W-1:0]            mem_raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]   mem_rdata_i,
  output tcw_pkg::tcw_status_t              status_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned MOVE  = COLUMNS * (ROWS - 1);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_RDW   = 4'd3;
  localparam logic [3:0] ST_TAB   = 4'd4;
  localparam logic [3:0] ST_LF    = 4'd5;
  localparam logic [3:0] ST_SCR   = 4'd6;
  localparam logic [3:0] ST_SCRD  = 4'd7;
  localparam logic [3:0] ST_FILL  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic                op_q, op_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic                adv_q, adv_d;
  logic [RADDR_W-1:0]  addr_q, addr_d;
  logic [CELL_W-1:0]   data_q, data_d;
  logic [ADDR_W-1:0]   cur_idx;
  logic [CW-1:0]       col_inc;
  logic                col_last;
  logic                addr_ok;

  assign cur_idx  = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
  assign col_inc  = col_q + CW'(1);
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign addr_ok  = (32'(addr_q) < CELLS);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    op_d        = op_q;
    ch_d        = ch_q;
    adv_d       = adv_q;
    addr_d      = addr_q;
    data_d      = data_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_idx;
    mem_wdata_o = {attr_i, ch_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = ADDR_W'(addr_q);
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = '0;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_op_i;
          ch_d    = in_char_i;
          adv_d   = in_adv_i;
          addr_d  = in_addr_i;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        data_d = '0;
        if (op_q == OP_READ) begin
          if (addr_ok) begin
            mem_re_o = 1'b1;
            state_d  = ST_RDW;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          case (ch_q)
            CODE_TAB: state_d = ST_TAB;
            CODE_LF:  state_d = ST_LF;
            CODE_CR:  state_d = ST_DONE;
            default: begin
              mem_we_o = 1'b1;
              state_d  = ST_DONE;
              if (adv_q) begin
                if (col_last) begin
                  state_d = ST_LF;
                end else begin
                  col_d = col_inc;
                end
              end
            end
          endcase
        end
      end
      ST_RDW: begin
        data_d  = mem_rdata_i;
        state_d = ST_DONE;
      end
      ST_TAB: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {attr_i, CODE_SPACE};
        if (col_last) begin
          state_d = ST_LF;
        end else begin
          col_d = col_inc;
          if (col_inc[1:0] == 2'b00) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_LF: begin
        col_d = '0;
        if (32'(row_q) < ROWS - 1) begin
          row_d   = row_q + RW'(1);
          state_d = ST_DONE;
        end else begin
          cnt_d   = '0;
          state_d = ST_SCR;
        end
      end
      ST_SCR: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ADDR_W'(32'(cnt_q) + COLUMNS);
        mem_we_o    = (cnt_q != '0);
        mem_waddr_o = cnt_q - ADDR_W'(1);
        mem_wdata_o = mem_rdata_i;
        cnt_d       = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(MOVE - 1)) begin
          state_d = ST_SCRD;
        end
      end
      ST_SCRD: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q - ADDR_W'(1);
        mem_wdata_o = mem_rdata_i;
        state_d     = ST_FILL;
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = blank_i;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_pos_o  = POS_W'(32'(row_q) * COLUMNS + 32'(col_q));
  assign res_data_o = data_q;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.idle     = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ch_q   <= ch_d;
    adv_q  <= adv_d;
    addr_q <= addr_d;
    data_q <= data_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/text_console_character_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_character_writer
// text-mode console: cursor, cell store, tab, line feed with scroll, cell read
// ----------------------------------------------------------------------------
// ordinary character writes its cell; carriage return and out-of-range read write
//   nothing; in-range read reads the cell; line feed goes to the next row, column 0;
//   tab writes spaces up to the next column that is a multiple of 4; a wrap at
//   the last column adds the line feed step; a line feed on the last row scrolls
// a scroll moves every row up one and fills the last row with the blank cell
// one transaction at a time: the next is accepted after its result is registered
// reset: cursor to 0, attribute 7, blank cell 0; then a clearing pass over all
//   COLUMNS*ROWS cells zeroes the store, no input accepted meanwhile
// ----------------------------------------------------------------------------
module text_console_character_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcw_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // char_code [7:0], advance [8], read_address [19:9], zero [23:20]
  input  wire logic [tcw_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // cursor_position [10:0], read_data [26:11], zero [31:27]
  output logic      [tcw_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import tcw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [ATTR_W-1:0]  attr_q;
  logic [CELL_W-1:0]  blank_q;
  logic               out_valid_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [CELL_W-1:0]  out_data_q;
  logic               res_valid;
  logic               res_ready;
  logic [POS_W-1:0]   res_pos;
  logic [CELL_W-1:0]  res_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;
  tcw_status_t        status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q  <= ATTR_RESET;
      blank_q <= BLANK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEXT_ATTR:  attr_q  <= cfg_wdata_i[ATTR_W-1:0];
        REG_BLANK_CELL: blank_q <= cfg_wdata_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .blank_i     (blank_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_char_i   (s_axis_tdata[7:0]),
    .in_adv_i    (s_axis_tdata[8]),
    .in_addr_i   (s_axis_tdata[19:9]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_pos_o   (res_pos),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .status_o    (status)
  );

  tcw_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_pos_q  <= res_pos;
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_data_q, out_pos_q};

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !s_axis_tready
  ) else $error("input ready during clearing pass");

  a_one_at_a_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !status.idle)
  ) else $error("engine still idle after accepting a transaction");

  a_result_from_busy_engine : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!status.idle && !status.clearing)
  ) else $error("result appeared without a transaction in work");

endmodule
`default_nettype wire
